// ===== hdl/irrs_pkg.sv =====
// Package for the IR remote sampling receiver: types, constants, key table.
package irrs_pkg;

    localparam int BITS_PER_BYTE_DEF   = 8;
    localparam int BYTES_PER_FRAME_DEF = 4;
    localparam logic [7:0] SAMPLE_PERIOD_RST = 8'd255;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam int KEY_COUNT = 30;

    typedef struct packed {
        logic       func;
        logic       ir_level;
        logic [1:0] key_index;
    } t_item;

    typedef struct packed {
        logic       capturing;
        logic       frame_done;
        logic [7:0] frame_byte;
        logic [7:0] key_char;
    } t_result;

    typedef logic [7:0] t_cfg;

    // Capture stage status after the current beat
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] sel_byte;
        logic [7:0] key_lo;
        logic [7:0] key_hi;
    } t_cap_status;

    localparam logic [7:0] KEY_LO [KEY_COUNT] = '{
        8'd102, 8'd102, 8'd166, 8'd166, 8'd105, 8'd86,  8'd169, 8'd86,
        8'd169, 8'd154, 8'd106, 8'd106, 8'd170, 8'd85,  8'd150, 8'd149,
        8'd154, 8'd149, 8'd101, 8'd101, 8'd165, 8'd165, 8'd89,  8'd89,
        8'd153, 8'd153, 8'd105, 8'd90,  8'd90,  8'd150
    };

    localparam logic [7:0] KEY_HI [KEY_COUNT] = '{
        8'd1, 8'd2, 8'd1, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1,
        8'd2, 8'd2, 8'd1, 8'd2, 8'd1, 8'd2, 8'd2, 8'd1,
        8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 8'd2,
        8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 8'd1
    };

    localparam logic [7:0] KEY_CH [KEY_COUNT] = '{
        "S", "P", "I", "p", "U", "D", "L", "R",
        "O", "C", "c", "V", "v", "o", "E", "s",
        "T", "1", "2", "3", "4", "5", "6", "7",
        "8", "9", "0", "*", "#", "r"
    };

    // First matching entry wins; 0 when nothing matches
    function automatic logic [7:0] lookup_key(input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] ch;
        ch = 8'd0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (KEY_LO[i] == lo && KEY_HI[i] == hi) begin
                ch = KEY_CH[i];
            end
        end
        return ch;
    endfunction

endpackage

// ===== hdl/irrs_chan_if.sv =====
// Valid/ready channel carrying one payload per beat.
interface irrs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/irrs_key_lookup.sv =====
// Key decoder: maps frame bytes 2 and 3 to an ASCII key character.
module irrs_key_lookup
    import irrs_pkg::*;
(
    input  logic [7:0] i_lo,
    input  logic [7:0] i_hi,
    output logic [7:0] o_char
);

    always_comb begin
        o_char = lookup_key(i_lo, i_hi);
    end

endmodule

// ===== hdl/irrs_capture.sv =====
// Capture engine: edge detect, sample timer, bit/byte position and frame store.
module irrs_capture
    import irrs_pkg::*;
#(
    parameter int BITS_PER_BYTE   = BITS_PER_BYTE_DEF,
    parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic [7:0]  i_sample_period,
    output t_cap_status o_status
);

    localparam int BIT_W  = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
    localparam int BYTE_W = $clog2(BYTES_PER_FRAME);
    localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(BITS_PER_BYTE - 1);
    localparam logic [BYTE_W-1:0] BYTE_LAST = BYTE_W'(BYTES_PER_FRAME - 1);

    logic                     r_busy, n_busy;
    logic                     r_prev, n_prev;
    logic [7:0]               r_tick, n_tick;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic [BYTE_W-1:0]        r_byte, n_byte;
    logic [BITS_PER_BYTE-1:0] r_store [BYTES_PER_FRAME];
    logic [BITS_PER_BYTE-1:0] n_store [BYTES_PER_FRAME];
    logic                     s_done;

    always_comb begin
        n_busy  = r_busy;
        n_prev  = r_prev;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_store = r_store;
        s_done  = 1'b0;
        if (i_step) begin
            if (i_item.func == FUNC_CLEAR) begin
                for (int i = 0; i < BYTES_PER_FRAME; i++) begin
                    n_store[i] = '0;
                end
            end else begin
                if (r_busy) begin
                    if (r_tick == i_sample_period) begin
                        n_tick = 8'd0;
                        // sensor is active low: store the inverted level
                        n_store[r_byte][r_bit] = ~i_item.ir_level;
                        if (r_bit < BIT_LAST) begin
                            n_bit = r_bit + 1'b1;
                        end else begin
                            n_bit = '0;
                            if (r_byte < BYTE_LAST) begin
                                n_byte = r_byte + 1'b1;
                            end else begin
                                n_byte = '0;
                                n_busy = 1'b0;
                                s_done = 1'b1;
                            end
                        end
                    end else begin
                        n_tick = r_tick + 8'd1;
                    end
                end else if (r_prev && !i_item.ir_level) begin
                    // start edge counts as frame bit 0
                    n_busy        = 1'b1;
                    n_tick        = 8'd0;
                    n_byte        = '0;
                    n_bit         = BIT_W'(1);
                    n_store[0][0] = 1'b1;
                end
                n_prev = i_item.ir_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_prev <= 1'b1;
            r_tick <= 8'd0;
            r_bit  <= '0;
            r_byte <= '0;
            for (int i = 0; i < BYTES_PER_FRAME; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_busy  <= n_busy;
            r_prev  <= n_prev;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_store <= n_store;
        end
    end

    always_comb begin
        o_status.busy     = n_busy;
        o_status.done     = s_done;
        o_status.sel_byte = 8'(n_store[BYTE_W'(i_item.key_index)]);
        o_status.key_lo   = 8'(n_store[2]);
        o_status.key_hi   = 8'(n_store[3]);
    end

    // idle always means the positions are back at the frame start
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_bit == '0 && r_byte == '0))
        else $error("position not cleared while idle");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && s_done) |=> !r_busy)
        else $error("still busy after last frame bit");

endmodule

// ===== hdl/ir_remote_sampling_receiver.sv =====
// Top level of the IR remote sampling receiver.
//
//  port      dir  payload                                    beat when
//  i_item    in   func, ir_level, key_index                  valid & ready
//  o_result  out  capturing, frame_done, frame_byte, key_char valid & ready
//  i_cfg     in   sample_period (8 bits)                     valid & ready
//
// One result per item, registered in the cycle after the item beat; an item is
// taken every cycle while ready is high. The capture update and key decode sit
// between the item port and the result register. i_item.ready drops only while
// a result waits and o_result.ready is low. i_cfg is always ready. Synchronous
// active-low reset clears capture state, frame store, last key; sample_period to 255.
module ir_remote_sampling_receiver
    import irrs_pkg::*;
#(
    parameter int BITS_PER_BYTE   = BITS_PER_BYTE_DEF,
    parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    irrs_chan_if.sink      i_item,
    irrs_chan_if.source    o_result,
    irrs_chan_if.sink      i_cfg
);

    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    logic [7:0]  r_last_key;
    logic [7:0]  r_sample_period;
    logic        s_step;
    logic [7:0]  s_lookup;
    logic [7:0]  s_key;
    t_cap_status s_cap;
    t_item       s_item;

    assign s_item       = i_item.payload;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign s_step       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    irrs_capture #(
        .BITS_PER_BYTE   (BITS_PER_BYTE),
        .BYTES_PER_FRAME (BYTES_PER_FRAME)
    ) u_capture (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (s_step),
        .i_item          (s_item),
        .i_sample_period (r_sample_period),
        .o_status        (s_cap)
    );

    irrs_key_lookup u_key_lookup (
        .i_lo   (s_cap.key_lo),
        .i_hi   (s_cap.key_hi),
        .o_char (s_lookup)
    );

    always_comb begin
        if (s_item.func == FUNC_CLEAR) begin
            s_key = s_cap.busy ? 8'd0 : s_lookup;
        end else begin
            s_key = s_cap.busy ? r_last_key : s_lookup;
        end
        n_result.capturing  = s_cap.busy;
        n_result.frame_done = s_cap.done;
        n_result.frame_byte = s_cap.busy ? 8'd0 : s_cap.sel_byte;
        n_result.key_char   = s_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_last_key      <= 8'd0;
            r_sample_period <= SAMPLE_PERIOD_RST;
        end else begin
            if (s_step) begin
                r_out_valid <= 1'b1;
                r_last_key  <= s_key;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_sample_period <= i_cfg.payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_result;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.frame_done) |-> !r_result.capturing)
        else $error("frame_done while still capturing");

    a_busy_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.capturing) |-> (r_result.frame_byte == 8'd0))
        else $error("frame byte shown while capturing");

    a_clear_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_step && s_item.func == FUNC_CLEAR) |=> (r_last_key == 8'd0))
        else $error("last key survived a clear");

    a_key_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_step |=> (r_result.key_char == r_last_key))
        else $error("last key differs from reported key");

endmodule
